// ===== rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg: shared definitions for the rendezvous channel matcher
// Depths, index widths and result status codes.
// ----------------------------------------------------------------------------
package rcm_pkg;

	localparam int MSG_DEPTH    = 16;
	localparam int WAIT_DEPTH   = 16;
	localparam int TASK_ID_BITS = 8;

	// Task ids are carried on 8-bit ports; bits above the port width are dropped.
	localparam int TID_W = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;

	localparam int MSG_AW  = $clog2(MSG_DEPTH);
	localparam int WAIT_AW = $clog2(WAIT_DEPTH);
	localparam int MSG_CW  = $clog2(MSG_DEPTH + 1);
	localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_HANDED   = 3'd0,
		ST_STORED   = 3'd1,
		ST_RECEIVED = 3'd2,
		ST_QUEUED   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	localparam logic REQ_SEND = 1'b0;
	localparam logic REQ_RECV = 1'b1;

endpackage

// ===== rtl/rendezvous_channel_matcher.sv =====
// ----------------------------------------------------------------------------
// rendezvous_channel_matcher: pairs senders with waiting receivers
// Two circular FIFOs in synchronous memories: stored message words and
// waiting receiver task ids. Each request pushes or pops at most one of them.
// ----------------------------------------------------------------------------
// Result: a request taken at a clock edge gives its result word, marked by done,
//   during the following cycle; one result per request, also when a full FIFO moves nothing.
// Throughput: one request per cycle; a request touches one port of one FIFO
//   memory, so busy never rises and the receiver cannot stall the block.
// Reset: arst_n clears heads, tails, counts and done; memory contents stay
//   undefined and are only read behind a nonzero count.
module rendezvous_channel_matcher (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    req_type,
	input  logic [7:0]              task_id,
	input  logic signed [63:0]      msg_value,
	output logic                    done,
	output rcm_pkg::status_t        status,
	output logic [7:0]              woken_task,
	output logic [7:0]              scheduling_task,
	output logic signed [63:0]      out_value
);
	import rcm_pkg::*;

	// FIFO memories
	logic [63:0]      msg_mem  [MSG_DEPTH];
	logic [TID_W-1:0] wait_mem [WAIT_DEPTH];

	// FIFO pointers and fill counts
	logic [MSG_AW-1:0]  msg_head_q, msg_tail_q;
	logic [MSG_CW-1:0]  msg_cnt_q;
	logic [WAIT_AW-1:0] wait_head_q, wait_tail_q;
	logic [WAIT_CW-1:0] wait_cnt_q;

	// Result stage
	logic               done_s1;
	status_t            status_s1;
	logic [7:0]         sched_s1;
	logic [63:0]        val_s1;
	logic [63:0]        msg_rd_s1;
	logic [TID_W-1:0]   wait_rd_s1;

	// Decode of the current request
	logic               accept;
	logic               msg_push, msg_pop, wait_push, wait_pop;
	logic               msg_empty, msg_full, wait_empty, wait_full;
	status_t            status_d;
	logic [TID_W-1:0]   task_d;

	// The channel has no stall source: every request completes in one memory access.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign task_d = task_id[TID_W-1:0];

	assign msg_empty  = (msg_cnt_q == '0);
	assign msg_full   = (msg_cnt_q == MSG_CW'(MSG_DEPTH));
	assign wait_empty = (wait_cnt_q == '0);
	assign wait_full  = (wait_cnt_q == WAIT_CW'(WAIT_DEPTH));

	// Pick the FIFO that this request moves and the status it reports.
	always_comb begin
		msg_push  = 1'b0;
		msg_pop   = 1'b0;
		wait_push = 1'b0;
		wait_pop  = 1'b0;
		status_d  = ST_FULL;
		if (req_type == REQ_SEND) begin
			if (!wait_empty) begin
				// hand the word straight to the oldest waiting receiver
				wait_pop = accept;
				status_d = ST_HANDED;
			end else if (!msg_full) begin
				msg_push = accept;
				status_d = ST_STORED;
			end
		end else begin
			if (!msg_empty) begin
				msg_pop  = accept;
				status_d = ST_RECEIVED;
			end else if (!wait_full) begin
				// park the receiver until a sender shows up
				wait_push = accept;
				status_d  = ST_QUEUED;
			end
		end
	end

	// Message memory: write at the tail, registered read at the head.
	// A pop never shares an edge with a push on the same FIFO, so no bypass is needed.
	always_ff @(posedge clk) begin
		if (msg_push) begin
			msg_mem[msg_tail_q] <= msg_value;
		end
		if (msg_pop) begin
			msg_rd_s1 <= msg_mem[msg_head_q];
		end
	end

	// Waiter memory: same organization, holds receiver task ids.
	always_ff @(posedge clk) begin
		if (wait_push) begin
			wait_mem[wait_tail_q] <= task_d;
		end
		if (wait_pop) begin
			wait_rd_s1 <= wait_mem[wait_head_q];
		end
	end

	// Advance pointers and counts; wrap indexes at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_head_q  <= '0;
			msg_tail_q  <= '0;
			msg_cnt_q   <= '0;
			wait_head_q <= '0;
			wait_tail_q <= '0;
			wait_cnt_q  <= '0;
		end else begin
			if (msg_push) begin
				msg_tail_q <= (msg_tail_q == MSG_AW'(MSG_DEPTH - 1)) ? '0 : msg_tail_q + 1'b1;
				msg_cnt_q  <= msg_cnt_q + 1'b1;
			end
			if (msg_pop) begin
				msg_head_q <= (msg_head_q == MSG_AW'(MSG_DEPTH - 1)) ? '0 : msg_head_q + 1'b1;
				msg_cnt_q  <= msg_cnt_q - 1'b1;
			end
			if (wait_push) begin
				wait_tail_q <= (wait_tail_q == WAIT_AW'(WAIT_DEPTH - 1)) ?
					'0 : wait_tail_q + 1'b1;
				wait_cnt_q  <= wait_cnt_q + 1'b1;
			end
			if (wait_pop) begin
				wait_head_q <= (wait_head_q == WAIT_AW'(WAIT_DEPTH - 1)) ?
					'0 : wait_head_q + 1'b1;
				wait_cnt_q  <= wait_cnt_q - 1'b1;
			end
		end
	end

	// Result strobe: raised in the cycle after each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Result payload; fields with no meaning for the status are held at zero.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			sched_s1  <= (status_d == ST_HANDED) ? 8'(task_d) : 8'd0;
			val_s1    <= (status_d == ST_HANDED) ? msg_value : 64'd0;
		end
	end

	assign done            = done_s1;
	assign status          = status_s1;
	assign scheduling_task = sched_s1;
	assign woken_task      = (status_s1 == ST_HANDED) ? 8'(wait_rd_s1) : 8'd0;
	assign out_value       = (status_s1 == ST_RECEIVED) ? msg_rd_s1 : val_s1;

`ifndef SYNTHESIS
	// A channel never holds stored words and parked receivers at once.
	a_one_side_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!(!msg_empty && !wait_empty))
		else $error("message and waiter FIFOs both nonempty");

	// Fill counts stay within their depths.
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_cnt_q <= MSG_CW'(MSG_DEPTH)) && (wait_cnt_q <= WAIT_CW'(WAIT_DEPTH)))
		else $error("FIFO count beyond depth");

	// Every accepted request yields a result strobe in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result strobe");

	// A handoff to a waiter removes exactly one waiter and leaves messages alone.
	a_handoff_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_SEND) && !wait_empty) |=>
		(wait_cnt_q == $past(wait_cnt_q) - 1'b1) && (msg_cnt_q == $past(msg_cnt_q)))
		else $error("handoff did not pop the waiter FIFO");
`endif

endmodule
